@@ hdl/animation_frame_sequencer_defines.svh @@
// Assertion helpers for the frame sequencer.
// Every property is sampled on i_clk and ignored while i_rst_n is low.
`ifndef ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define AFS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AFS_ASSERT_IMPLY(label, ante, cons, msg)
`define AFS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/afs_pkg.sv @@
`timescale 1ns / 1ps

package afs_pkg;

    // Field widths of the item and result transactions
    localparam int MODE_W    = 2;
    localparam int ELAPSED_W = 16;
    localparam int SLOT_W    = 4;
    localparam int LEN_W     = 16;
    localparam int FRAME_W   = 4;
    localparam int TIF_W     = 17;

    // Configuration port
    localparam int COUNT_W    = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    // Register index, taken from paddr[2]
    localparam logic REG_REPEAT = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    // Configuration handed from the register file to the sequencer
    typedef struct packed {
        logic               repeat_enable;
        logic [COUNT_W-1:0] frame_count;
    } t_cfg;

endpackage

@@ hdl/afs_ifs.sv @@
`timescale 1ns / 1ps

// Item channel: tick, table write or sequence reset
interface afs_item_if;
    logic                         valid;
    logic                         ready;
    logic [afs_pkg::MODE_W-1:0]    mode;
    logic [afs_pkg::ELAPSED_W-1:0] elapsed;
    logic [afs_pkg::SLOT_W-1:0]    frame_slot;
    logic [afs_pkg::LEN_W-1:0]     frame_length;

    modport source (output valid, output mode, output elapsed, output frame_slot,
                    output frame_length, input ready);
    modport sink   (input valid, input mode, input elapsed, input frame_slot,
                    input frame_length, output ready);
endinterface

// Result channel: one result per item
interface afs_result_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [afs_pkg::FRAME_W-1:0] frame_now;
    logic [afs_pkg::TIF_W-1:0]   time_in_frame;
    logic                        start_event;
    logic                        end_event;

    modport source (output valid, output status, output frame_now, output time_in_frame,
                    output start_event, output end_event, input ready);
    modport sink   (input valid, input status, input frame_now, input time_in_frame,
                    input start_event, input end_event, output ready);
endinterface

@@ hdl/afs_ram.sv @@
`timescale 1ns / 1ps

// Single-port RAM, registered read
module afs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/afs_regs.sv @@
`timescale 1ns / 1ps

// APB register file: repeat mode and frame count
module afs_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [afs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [afs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [afs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output afs_pkg::t_cfg                     o_cfg
);

    logic                           r_repeat;
    logic [afs_pkg::COUNT_W-1:0]    r_count;
    logic                           w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes, decoded on the word address bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat <= 1'b0;
            r_count  <= afs_pkg::COUNT_W'(1);
        end else if (w_wr) begin
            unique case (paddr[2])
                afs_pkg::REG_REPEAT: r_repeat <= pwdata[0];
                afs_pkg::REG_COUNT:  r_count  <= pwdata[afs_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (paddr[2])
            afs_pkg::REG_REPEAT: prdata = {{(afs_pkg::APB_DATA_W-1){1'b0}}, r_repeat};
            afs_pkg::REG_COUNT:
                prdata = {{(afs_pkg::APB_DATA_W-afs_pkg::COUNT_W){1'b0}}, r_count};
            default: prdata = '0;
        endcase
    end

    assign o_cfg.repeat_enable = r_repeat;
    assign o_cfg.frame_count   = r_count;

endmodule

@@ hdl/animation_frame_sequencer.sv @@
`timescale 1ns / 1ps
// Tick: accepted in idle, then one registered table read and one compare per frame
// crossed in the compare state; a held sequence stops comparing at its last frame.
// The output state loads the result register once it is free; write and reset items
// go there straight from idle. The next item is taken only back in idle.
// Reset (synchronous, active low): frame 0, time 0, flags clear, repeat off, count 1;
// the duration table is not cleared and reads undefined until written.
`include "animation_frame_sequencer_defines.svh"

module animation_frame_sequencer #(
    parameter int MAX_FRAMES = 16,
    parameter int TIME_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    afs_item_if.sink                          i_item,
    afs_result_if.source                      o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [afs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [afs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [afs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int IW = $clog2(MAX_FRAMES);
    localparam int NW = (IW + 1 > afs_pkg::COUNT_W) ? IW + 1 : afs_pkg::COUNT_W;
    localparam int AW = TIME_BITS + 1;
    localparam int ELW_PAD = 16;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    afs_pkg::t_cfg          w_cfg;

    logic [1:0]             r_state, n_state;
    logic [IW-1:0]          r_frame_index, n_frame_index;
    logic [AW-1:0]          r_accum, n_accum;
    logic                   r_started, n_started;
    logic                   r_ended, n_ended;
    logic                   r_status, n_status;
    logic                   r_sev, n_sev;
    logic                   r_eev, n_eev;
    logic                   r_out_valid;
    logic                   r_out_status;
    logic [afs_pkg::FRAME_W-1:0] r_out_frame;
    logic [afs_pkg::TIF_W-1:0]   r_out_time;
    logic                   r_out_sev;
    logic                   r_out_eev;

    logic                   w_acc;
    logic                   w_load;
    logic [NW-1:0]          w_fc;
    logic [NW-1:0]          w_n;
    logic [IW-1:0]          w_last;
    logic [IW-1:0]          w_idx_cl;
    logic                   w_has_next;
    logic [TIME_BITS+ELW_PAD-1:0] w_el_ext;
    logic [TIME_BITS-1:0]   w_elapsed;
    logic [TIME_BITS+ELW_PAD-1:0] w_len_ext;
    logic [TIME_BITS-1:0]   w_len_raw;
    logic [TIME_BITS-1:0]   w_len;
    logic [IW+afs_pkg::SLOT_W-1:0] w_slot_ext;
    logic                   w_slot_ok;
    logic [TIME_BITS-1:0]   w_rdata;
    logic [TIME_BITS-1:0]   w_dur;
    logic [AW-1:0]          w_dur_ext;
    logic                   w_ge;
    logic                   ram_we;
    logic [IW-1:0]          ram_addr;
    logic [IW+afs_pkg::FRAME_W-1:0] w_frame_ext;
    logic [AW+afs_pkg::TIF_W-1:0]   w_accum_ext;

    // Configuration registers
    afs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Duration table
    afs_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (w_len),
        .o_rdata (w_rdata)
    );

    // Frames in use: zero acts as one, clamp to table depth
    assign w_fc   = NW'(w_cfg.frame_count);
    assign w_n    = (w_fc == '0) ? NW'(1) :
                    ((w_fc > NW'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : w_fc);
    assign w_last = IW'(w_n - NW'(1));
    assign w_idx_cl   = (NW'(r_frame_index) >= w_n) ? w_last : r_frame_index;
    assign w_has_next = (NW'(r_frame_index) + NW'(1)) < w_n;

    // Input times masked to TIME_BITS
    assign w_el_ext  = {{TIME_BITS{1'b0}}, i_item.elapsed};
    assign w_elapsed = w_el_ext[TIME_BITS-1:0];
    assign w_len_ext = {{TIME_BITS{1'b0}}, i_item.frame_length};
    assign w_len_raw = w_len_ext[TIME_BITS-1:0];
    assign w_len     = (w_len_raw == '0) ? TIME_BITS'(1) : w_len_raw;

    // Slot decode; slots past the table are dropped
    assign w_slot_ext = {{IW{1'b0}}, i_item.frame_slot};
    assign w_slot_ok  = 32'(i_item.frame_slot) < MAX_FRAMES;

    // Duration of the frame read last cycle; zero counts as one
    assign w_dur     = (w_rdata == '0) ? TIME_BITS'(1) : w_rdata;
    assign w_dur_ext = {1'b0, w_dur};
    assign w_ge      = r_accum >= w_dur_ext;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_load       = (r_state == S_OUT) && (!r_out_valid || o_result.ready);

    // Sequencer: accept, then for ticks one table compare per cycle until time fits the frame or the end holds
    always_comb begin
        n_state       = r_state;
        n_frame_index = r_frame_index;
        n_accum       = r_accum;
        n_started     = r_started;
        n_ended       = r_ended;
        n_status      = r_status;
        n_sev         = r_sev;
        n_eev         = r_eev;
        ram_we        = 1'b0;
        ram_addr      = r_frame_index;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_status = 1'b0;
                    n_sev    = 1'b0;
                    n_eev    = 1'b0;
                    n_state  = S_OUT;
                    unique case (i_item.mode)
                        afs_pkg::MODE_TICK: begin
                            n_state       = S_CMP;
                            n_frame_index = w_idx_cl;
                            ram_addr      = w_idx_cl;
                            n_accum       = r_accum + AW'(w_elapsed);
                            if (!r_started && (w_idx_cl == '0)) begin
                                n_started = 1'b1;
                                n_ended   = 1'b0;
                                n_sev     = 1'b1;
                            end
                        end
                        afs_pkg::MODE_WRITE: begin
                            ram_we   = w_slot_ok;
                            ram_addr = w_slot_ext[IW-1:0];
                        end
                        afs_pkg::MODE_RESET: begin
                            n_frame_index = '0;
                            n_accum       = '0;
                            n_started     = 1'b0;
                            n_ended       = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CMP: begin
                if (!w_ge) begin
                    n_state = S_OUT;
                end else begin
                    n_accum = r_accum - w_dur_ext;
                    priority if (w_has_next) begin
                        n_frame_index = r_frame_index + IW'(1);
                        ram_addr      = r_frame_index + IW'(1);
                    end else if (w_cfg.repeat_enable) begin
                        // wrap to the first frame, leftover time carries on
                        n_eev         = r_eev | !r_ended;
                        n_ended       = 1'b1;
                        n_started     = 1'b0;
                        n_frame_index = '0;
                        ram_addr      = '0;
                    end else begin
                        // hold at the end of the last frame
                        n_frame_index = w_last;
                        n_accum       = w_dur_ext;
                        n_eev         = r_eev | !r_ended;
                        n_ended       = 1'b1;
                        n_status      = 1'b1;
                        n_state       = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_index <= '0;
            r_accum       <= '0;
            r_started     <= 1'b0;
            r_ended       <= 1'b0;
            r_status      <= 1'b0;
            r_sev         <= 1'b0;
            r_eev         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_frame_index <= n_frame_index;
            r_accum       <= n_accum;
            r_started     <= n_started;
            r_ended       <= n_ended;
            r_status      <= n_status;
            r_sev         <= n_sev;
            r_eev         <= n_eev;
        end
    end

    // Output register, holds a result until the transaction completes
    assign w_frame_ext = {{afs_pkg::FRAME_W{1'b0}}, r_frame_index};
    assign w_accum_ext = {{afs_pkg::TIF_W{1'b0}}, r_accum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_frame  <= w_frame_ext[afs_pkg::FRAME_W-1:0];
            r_out_time   <= w_accum_ext[afs_pkg::TIF_W-1:0];
            r_out_sev    <= r_sev;
            r_out_eev    <= r_eev;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out_status;
    assign o_result.frame_now     = r_out_frame;
    assign o_result.time_in_frame = r_out_time;
    assign o_result.start_event   = r_out_sev;
    assign o_result.end_event     = r_out_eev;

    // Checks
    `AFS_ASSERT_NEXT(a_tick_reads_table, w_acc && (i_item.mode == afs_pkg::MODE_TICK), r_state == S_CMP, "tick did not start a table read")
    `AFS_ASSERT_IMPLY(a_finish_sets_ended, (r_state == S_OUT) && r_status, r_ended, "finished without ended flag")
    `AFS_ASSERT_IMPLY(a_end_event_ended, (r_state == S_OUT) && r_eev, r_ended, "end event without ended flag")
    `AFS_ASSERT_NEXT(a_result_waits, (r_state == S_OUT) && r_out_valid && !o_result.ready, r_state == S_OUT, "result dropped while output stalled")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import afs_pkg::*;

    localparam int NUM_SLOTS      = 1 << SLOT_W;
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_PERCENT   = 24;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int CYCLE_LIMIT    = 40_000_000;
    localparam int RANDOM_PHASES  = 13;

    // Unused mode: the block must leave its state alone
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic               status;
        logic [FRAME_W-1:0] frame_now;
        logic [TIF_W-1:0]   time_in_frame;
        logic               start_event;
        logic               end_event;
    } t_frame_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    afs_item_if   item_ch ();
    afs_result_if result_ch ();

    animation_frame_sequencer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Sequencer state as the testbench sees it
    logic [LEN_W-1:0]   frame_len_tab [NUM_SLOTS];
    int unsigned        seq_frame;
    logic [TIF_W-1:0]   seq_accum;
    bit                 seq_started;
    bit                 seq_ended;
    bit                 cfg_repeat;
    logic [COUNT_W-1:0] cfg_count;

    t_frame_result expected_frames [$];
    int unsigned   mismatch_count;
    bit            no_idle;
    bit            holdoff_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** animation_frame_sequencer: FAILED **");
        $finish;
    end

    // Duration of a frame; zero counts as one tick
    function automatic logic [TIF_W-1:0] frame_span(input int unsigned slot);
        return (frame_len_tab[slot] == '0) ? TIF_W'(1) : TIF_W'(frame_len_tab[slot]);
    endfunction

    // Apply one item to the predicted state and return the result it must give
    function automatic t_frame_result advance_sequence(input logic [MODE_W-1:0]    mode,
                                                       input logic [ELAPSED_W-1:0] elapsed,
                                                       input logic [SLOT_W-1:0]    slot,
                                                       input logic [LEN_W-1:0]     length);
        t_frame_result    res;
        int unsigned      in_use;
        int unsigned      idx;
        logic [TIF_W-1:0] span;
        bit               held;
        res  = '0;
        held = 1'b0;
        case (mode)
            MODE_TICK: begin
                in_use = (cfg_count == 0) ? 1 :
                         (cfg_count > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_count);
                if (seq_frame >= in_use) seq_frame = in_use - 1;
                if (!seq_started && seq_frame == 0) begin
                    seq_started     = 1'b1;
                    seq_ended       = 1'b0;
                    res.start_event = 1'b1;
                end
                idx       = seq_frame;
                span      = frame_span(idx);
                seq_accum = seq_accum + elapsed;
                // step over every frame that has run out
                while (!held && seq_accum >= span) begin
                    seq_accum = seq_accum - span;
                    if (idx + 1 < in_use) begin
                        idx++;
                        span = frame_span(idx);
                    end else if (cfg_repeat) begin
                        if (!seq_ended) begin
                            seq_ended     = 1'b1;
                            res.end_event = 1'b1;
                        end
                        idx         = 0;
                        span        = frame_span(0);
                        seq_started = 1'b0;
                    end else begin
                        seq_accum = span;
                        if (!seq_ended) begin
                            seq_ended     = 1'b1;
                            res.end_event = 1'b1;
                        end
                        res.status = 1'b1;
                        held       = 1'b1;
                    end
                end
                seq_frame = idx;
            end
            MODE_WRITE: begin
                frame_len_tab[slot] = (length == '0) ? LEN_W'(1) : length;
            end
            MODE_RESET: begin
                seq_frame   = 0;
                seq_accum   = '0;
                seq_started = 1'b0;
                seq_ended   = 1'b0;
            end
            default: ;
        endcase
        res.frame_now     = FRAME_W'(seq_frame);
        res.time_in_frame = seq_accum;
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) log_mismatch($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_frames.size() == 0) begin
                log_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_frames.pop_front();
                compare_field("status", want.status, result_ch.status);
                compare_field("frame_now", want.frame_now, result_ch.frame_now);
                compare_field("time_in_frame", want.time_in_frame, result_ch.time_in_frame);
                compare_field("start_event", want.start_event, result_ch.start_event);
                compare_field("end_event", want.end_event, result_ch.end_event);
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off counted here
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
            end
            result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offer one item and wait until it is taken
    task automatic send_item(input logic [MODE_W-1:0]    mode,
                             input logic [ELAPSED_W-1:0] elapsed,
                             input logic [SLOT_W-1:0]    slot,
                             input logic [LEN_W-1:0]     length);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.mode         <= mode;
        item_ch.elapsed      <= elapsed;
        item_ch.frame_slot   <= slot;
        item_ch.frame_length <= length;
        do @(posedge i_clk); while (!item_ch.ready);
        expected_frames.insert(expected_frames.size(),
                               advance_sequence(mode, elapsed, slot, length));
    endtask

    // Mostly ticks crossing a frame or two, some long ones, table writes, resets and the spare mode
    task automatic send_random_item;
        int unsigned           roll;
        logic [MODE_W-1:0]     mode;
        logic [ELAPSED_W-1:0]  elapsed;
        logic [LEN_W-1:0]      length;
        roll = $urandom_range(99);
        mode = (roll < 68) ? MODE_TICK : (roll < 88) ? MODE_WRITE :
               (roll < 95) ? MODE_RESET : MODE_SPARE;
        roll = $urandom_range(99);
        elapsed = (roll < 80) ? ELAPSED_W'($urandom_range(48)) :
                  (roll < 98) ? ELAPSED_W'($urandom_range(2000)) :
                                ELAPSED_W'($urandom_range(65535));
        roll = $urandom_range(99);
        length = (roll < 10) ? '0 :
                 (roll < 75) ? LEN_W'($urandom_range(40, 1)) :
                 (roll < 90) ? LEN_W'($urandom_range(1023)) :
                               LEN_W'($urandom_range(65535));
        send_item(mode, elapsed, SLOT_W'($urandom_range(NUM_SLOTS - 1)), length);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic await_idle;
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
    endtask

    // Register write followed by a read back
    task automatic config_write(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] mask;
        mask = (reg_sel == REG_COUNT) ? APB_DATA_W'((1 << COUNT_W) - 1) : APB_DATA_W'(1);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == REG_COUNT) cfg_count = value[COUNT_W-1:0];
        else cfg_repeat = value[0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (value & mask))
            log_mismatch($sformatf("register %0d read %0h, wrote %0h", reg_sel, prdata, value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Fill every slot before any tick reads one; zero and all-ones lengths included
    task automatic test_table_load;
        logic [LEN_W-1:0] length;
        for (int slot = 0; slot < NUM_SLOTS; slot++) begin
            length = (slot == 0) ? '0 : (slot == NUM_SLOTS - 1) ? '1 :
                     (slot == 1) ? LEN_W'(3) : (slot == 2) ? LEN_W'(5) : LEN_W'(10 * slot);
            send_item(MODE_WRITE, ELAPSED_W'($urandom), SLOT_W'(slot), length);
        end
    endtask

    task automatic test_directed_sequence;
        // one frame, hold at end: start, finish, stay finished
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_TICK, ELAPSED_W'(1), '0, '0);
        send_item(MODE_TICK, '1, '0, '0);
        send_item(MODE_SPARE, '1, '1, '1);
        send_item(MODE_RESET, '0, '0, '0);
        // repeat over three frames: wrap with end event, then a fresh start
        await_idle();
        config_write(REG_REPEAT, 1);
        config_write(REG_COUNT, 3);
        send_item(MODE_TICK, ELAPSED_W'(9), '0, '0);
        send_item(MODE_TICK, ELAPSED_W'(2), '0, '0);
        // full table, longest tick
        await_idle();
        config_write(REG_COUNT, 16);
        send_item(MODE_TICK, '1, '0, '0);
        // fewer frames than the current one: clamp, then hold at the end
        await_idle();
        config_write(REG_REPEAT, 0);
        config_write(REG_COUNT, 2);
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_TICK, '1, '0, '0);
        // count of zero acts as one frame
        await_idle();
        config_write(REG_COUNT, 0);
        send_item(MODE_TICK, ELAPSED_W'(5), '0, '0);
        send_item(MODE_RESET, '0, '0, '0);
        // count above the table size acts as the whole table
        await_idle();
        config_write(REG_COUNT, 31);
        send_item(MODE_TICK, ELAPSED_W'(100), '0, '0);
        send_item(MODE_WRITE, '0, SLOT_W'(2), '0);
        send_item(MODE_TICK, ELAPSED_W'(40), '0, '0);
    endtask

    task automatic test_random_phases;
        int unsigned           roll;
        logic [APB_DATA_W-1:0] count;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            roll  = $urandom_range(9);
            count = (roll == 0) ? APB_DATA_W'($urandom_range(1) ? $urandom_range(31, 17) : 0) :
                    (roll == 1) ? APB_DATA_W'(1) :
                    (roll == 2) ? APB_DATA_W'(16) : APB_DATA_W'($urandom_range(15, 2));
            await_idle();
            config_write(REG_REPEAT, APB_DATA_W'($urandom_range(1)));
            config_write(REG_COUNT, count);
            repeat ($urandom_range(140, 60)) send_random_item();
        end
    endtask

    // Receiver stalls long enough for the block to back up into its input
    task automatic test_output_backpressure;
        holdoff_req = 1'b1;
        repeat (50) send_random_item();
    endtask

    // Long stretch with neither side idling
    task automatic test_steady_stream;
        no_idle = 1'b1;
        repeat (250) send_random_item();
        no_idle = 1'b0;
    endtask

    // Sender waits for the block to empty between bursts
    task automatic test_drain_pause;
        repeat (4) begin
            repeat ($urandom_range(20, 5)) send_random_item();
            await_idle();
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_ch.valid        = 1'b0;
        item_ch.mode         = MODE_TICK;
        item_ch.elapsed      = '0;
        item_ch.frame_slot   = '0;
        item_ch.frame_length = '0;
        no_idle              = 1'b0;
        holdoff_req          = 1'b0;
        mismatch_count       = 0;
        seq_frame            = 0;
        seq_accum            = '0;
        seq_started          = 1'b0;
        seq_ended            = 1'b0;
        cfg_repeat           = 1'b0;
        cfg_count            = COUNT_W'(1);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_table_load();
        test_directed_sequence();
        test_random_phases();
        test_output_backpressure();
        test_steady_stream();
        test_drain_pause();

        await_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatch_count += expected_frames.size();
        if (mismatch_count == 0) begin
            $display("** animation_frame_sequencer: PASSED **");
        end else begin
            $display("** animation_frame_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
